// ===== rtl/core/lrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler package
// Shared types and constants of the longest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package lrts_pkg;

  localparam int SLOTS_DEF     = 8;
  localparam int TIME_BITS_DEF = 20;
  localparam int QUEUE_DEPTH   = 2;

  localparam int SLOT_FIELD_W = 3;
  localparam int ID_W         = 16;
  localparam int BURST_W      = 16;
  localparam int OUT_TIME_W   = 20;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ID_W-1:0]         task_id;
    logic [BURST_W-1:0]      burst;
  } lrts_in_t;

  typedef struct packed {
    logic                    idle;
    logic [ID_W-1:0]         chosen_id;
    logic [SLOT_FIELD_W-1:0] chosen_slot;
    logic [OUT_TIME_W-1:0]   run_start;
    logic                    finished;
    logic [OUT_TIME_W-1:0]   turnaround;
    logic [OUT_TIME_W-1:0]   waiting;
  } lrts_out_t;

  typedef struct packed {
    logic                    tick;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ID_W-1:0]         task_id;
    logic [BURST_W-1:0]      burst;
  } lrts_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts items, drops loads aimed beyond the table and queues commands.
// ----------------------------------------------------------------------------
module lrts_front #(
  parameter int SLOTS = lrts_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lrts_pkg::lrts_in_t  in_data,
  output logic                q_valid,
  output lrts_pkg::lrts_cmd_t q_cmd,
  input  logic                q_pop
);

  localparam int QD    = lrts_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QD - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QD);

  lrts_pkg::lrts_cmd_t q_mem_r [QD];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                keep;
  logic                push;
  logic                pop;
  lrts_pkg::lrts_cmd_t cmd;

  always_comb begin
    cmd.tick    = (in_data.kind == lrts_pkg::KIND_TICK);
    cmd.slot    = in_data.slot;
    cmd.task_id = in_data.task_id;
    cmd.burst   = in_data.burst;
    keep        = cmd.tick || (int'(in_data.slot) < SLOTS);
  end

  assign in_stall = (cnt_r == CNT_FULL);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lrts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler back end
// Holds the slot table, scans it for the longest remaining task and reports.
// ----------------------------------------------------------------------------
module lrts_back #(
  parameter int SLOTS     = lrts_pkg::SLOTS_DEF,
  parameter int TIME_BITS = lrts_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lrts_pkg::lrts_cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lrts_pkg::lrts_out_t out_data
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int EXT_W  = (SLOT_W > lrts_pkg::SLOT_FIELD_W) ? SLOT_W : lrts_pkg::SLOT_FIELD_W;
  localparam int TW     = (TIME_BITS > lrts_pkg::OUT_TIME_W) ? TIME_BITS : lrts_pkg::OUT_TIME_W;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  typedef struct packed {
    logic [lrts_pkg::ID_W-1:0]    task_id;
    logic [lrts_pkg::BURST_W-1:0] init_burst;
    logic [lrts_pkg::BURST_W-1:0] remaining;
  } rec_t;

  rec_t mem [SLOTS];
  rec_t rd_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  rec_t              mem_wd;

  logic [1:0]                   state_r, state_nxt;
  logic [SLOT_W-1:0]            idx_r, idx_nxt;
  logic                         chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0]            chk_idx_r, chk_idx_nxt;
  logic                         best_v_r, best_v_nxt;
  logic [SLOT_W-1:0]            best_idx_r, best_idx_nxt;
  logic [lrts_pkg::ID_W-1:0]    best_id_r, best_id_nxt;
  logic [lrts_pkg::BURST_W-1:0] best_rem_r, best_rem_nxt;
  logic [lrts_pkg::BURST_W-1:0] best_init_r, best_init_nxt;
  logic [SLOTS-1:0]             pend_r, pend_nxt;
  logic [TIME_BITS-1:0]         now_r, now_nxt;
  logic                         out_valid_r, out_valid_nxt;
  lrts_pkg::lrts_out_t          out_data_r, out_data_nxt;

  logic [EXT_W-1:0]             ld_ext;
  logic [SLOT_W-1:0]            ld_idx;
  logic [EXT_W-1:0]             best_ext;
  logic                         better;
  logic [lrts_pkg::BURST_W-1:0] rem_dec;
  logic [TIME_BITS-1:0]         now_inc;
  logic [TW-1:0]                start_ext;
  logic [TW-1:0]                tat;
  logic [TW-1:0]                bur;
  logic [TW-1:0]                wt;

  assign ld_ext    = EXT_W'(q_cmd.slot);
  assign ld_idx    = ld_ext[SLOT_W-1:0];
  assign best_ext  = EXT_W'(best_idx_r);
  assign rem_dec   = best_rem_r - 1'b1;
  assign now_inc   = (now_r == '1) ? now_r : now_r + 1'b1;
  assign start_ext = TW'(now_r);
  assign tat       = TW'(now_inc);
  assign bur       = TW'(best_init_r);
  assign wt        = (tat >= bur) ? tat - bur : '0;

  assign better = chk_v_r && pend_r[chk_idx_r] &&
                  (!best_v_r || (rd_q.remaining > best_rem_r) ||
                   ((rd_q.remaining == best_rem_r) && (rd_q.task_id < best_id_r)));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = idx_r;
    best_v_nxt    = best_v_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    best_rem_nxt  = best_rem_r;
    best_init_nxt = best_init_r;
    pend_nxt      = pend_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = ld_idx;
    mem_wd        = '{task_id: q_cmd.task_id, init_burst: q_cmd.burst,
                      remaining: q_cmd.burst};

    if (better) begin
      best_v_nxt    = 1'b1;
      best_idx_nxt  = chk_idx_r;
      best_id_nxt   = rd_q.task_id;
      best_rem_nxt  = rd_q.remaining;
      best_init_nxt = rd_q.init_burst;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.tick) begin
            state_nxt  = ST_SCAN;
            idx_nxt    = '0;
            best_v_nxt = 1'b0;
          end else begin
            mem_we           = 1'b1;
            pend_nxt[ld_idx] = (q_cmd.burst != '0);
          end
        end
      end
      ST_SCAN: begin
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt               = ST_IDLE;
          out_valid_nxt           = 1'b1;
          out_data_nxt            = '0;
          out_data_nxt.run_start  = start_ext[lrts_pkg::OUT_TIME_W-1:0];
          if (!best_v_r) begin
            out_data_nxt.idle = 1'b1;
          end else begin
            mem_we                   = 1'b1;
            mem_wa                   = best_idx_r;
            mem_wd                   = '{task_id: best_id_r, init_burst: best_init_r,
                                         remaining: rem_dec};
            now_nxt                  = now_inc;
            out_data_nxt.chosen_id   = best_id_r;
            out_data_nxt.chosen_slot = best_ext[lrts_pkg::SLOT_FIELD_W-1:0];
            if (rem_dec == '0) begin
              pend_nxt[best_idx_r]    = 1'b0;
              out_data_nxt.finished   = 1'b1;
              out_data_nxt.turnaround = tat[lrts_pkg::OUT_TIME_W-1:0];
              out_data_nxt.waiting    = wt[lrts_pkg::OUT_TIME_W-1:0];
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_v_r     <= 1'b0;
      best_v_r    <= 1'b0;
      pend_r      <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_v_r     <= chk_v_nxt;
      best_v_r    <= best_v_nxt;
      pend_r      <= pend_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_id_r   <= best_id_nxt;
    best_rem_r  <= best_rem_nxt;
    best_init_r <= best_init_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[idx_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result is only built once the whole table has been compared
  a_fin_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> ($past(state_r) == ST_DRAIN || $past(state_r) == ST_FIN))
    else $error("result stage entered without a finished scan");

  // the chosen slot is pending and still has work left
  a_best_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && best_v_r) |-> (pend_r[best_idx_r] && best_rem_r != '0))
    else $error("chosen slot is not a live task");

  // time moves by one, and only with a result that ran a task
  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    (now_r != $past(now_r)) |->
      (now_r == $past(now_r) + 1'b1 && out_valid_r && !out_data_r.idle))
    else $error("time advanced without a task being run");

  // a tick popped from the queue starts a scan
  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_cmd.tick) |=> (state_r == ST_SCAN))
    else $error("tick did not start a scan");

endmodule

`default_nettype wire

// ===== rtl/core/longest_remaining_time_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Longest-remaining-time scheduler
// Preemptive longest-remaining-time-first scheduler over a table of slots.
// ----------------------------------------------------------------------------
// A load item is written to the slot table in the back end and gives no
// result; a tick item scans the slot table, reading one slot a cycle, then
// takes a compare step (ST_DRAIN) and a step (ST_FIN) that updates the table
// and loads the output register once that register is free. The front end
// queues up to two items, so the input takes up to two items while a tick is at
// work and while a result waits in the output register. Loads with a slot
// beyond the table are taken and dropped. Time saturates at 2^TIME_BITS - 1.
module longest_remaining_time_scheduler_unit #(
  parameter int SLOTS     = lrts_pkg::SLOTS_DEF,
  parameter int TIME_BITS = lrts_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lrts_pkg::lrts_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lrts_pkg::lrts_out_t out_data
);

  logic                q_valid;
  logic                q_pop;
  lrts_pkg::lrts_cmd_t q_cmd;

  lrts_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  lrts_back #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/longest_remaining_time_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-remaining-time scheduler testbench
// Drives loads and ticks through the valid/stall input, tracks the slot table
// and the time count alongside the block, and checks every tick report in
// order while both channels idle and stall in several phases.
// ----------------------------------------------------------------------------
module longest_remaining_time_scheduler_unit_tb;

  localparam int          NSLOTS    = lrts_pkg::SLOTS_DEF;
  localparam int unsigned TIME_TOP  = (32'd1 << lrts_pkg::TIME_BITS_DEF) - 1;
  localparam int          RUN_LIMIT = 400000;
  localparam int          PHASE_LEN = 335;
  localparam int          SETTLE    = 4 * (NSLOTS + 3);
  localparam int          OTW       = lrts_pkg::OUT_TIME_W;

  class schedule_tracker;
    logic [lrts_pkg::ID_W-1:0]    task_of [NSLOTS];
    logic [lrts_pkg::BURST_W-1:0] burst_of [NSLOTS];
    logic [lrts_pkg::BURST_W-1:0] left_of [NSLOTS];
    bit                           live [NSLOTS];
    int unsigned                  now_count;
    lrts_pkg::lrts_out_t          due_reports[$];
    int                           errors;

    function new();
      foreach (live[k]) begin
        task_of[k]  = '0;
        burst_of[k] = '0;
        left_of[k]  = '0;
        live[k]     = 1'b0;
      end
      now_count = 0;
      errors    = 0;
    endfunction

    function string show(lrts_pkg::lrts_out_t r);
      return $sformatf("idle=%0d id=%h slot=%0d start=%0d fin=%0d tat=%0d wait=%0d",
                       r.idle, r.chosen_id, r.chosen_slot, r.run_start, r.finished,
                       r.turnaround, r.waiting);
    endfunction

    function void take_item(lrts_pkg::lrts_in_t item);
      lrts_pkg::lrts_out_t rep;
      int                  best;
      int unsigned         base;
      rep  = '0;
      best = -1;
      if (item.kind == lrts_pkg::KIND_LOAD) begin
        if (int'(item.slot) < NSLOTS) begin
          task_of[item.slot]  = item.task_id;
          burst_of[item.slot] = item.burst;
          left_of[item.slot]  = item.burst;
          live[item.slot]     = (item.burst != '0);
        end
        return;
      end
      for (int k = 0; k < NSLOTS; k++) begin
        if (!live[k]) continue;
        if (best < 0 || left_of[k] > left_of[best] ||
            (left_of[k] == left_of[best] && task_of[k] < task_of[best]))
          best = k;
      end
      rep.run_start = now_count[OTW-1:0];
      if (best < 0) begin
        rep.idle = 1'b1;
        due_reports.push_back(rep);
        return;
      end
      left_of[best] = left_of[best] - 1'b1;
      if (now_count < TIME_TOP) now_count++;
      rep.chosen_id   = task_of[best];
      rep.chosen_slot = lrts_pkg::SLOT_FIELD_W'(best);
      if (left_of[best] == '0) begin
        live[best]     = 1'b0;
        base           = burst_of[best];
        rep.finished   = 1'b1;
        rep.turnaround = now_count[OTW-1:0];
        rep.waiting    = (now_count >= base) ? OTW'(now_count - base) : '0;
      end
      due_reports.push_back(rep);
    endfunction

    function void match_report(lrts_pkg::lrts_out_t got);
      lrts_pkg::lrts_out_t want;
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t: expected no report / actual %s", $time, show(got));
        return;
      end
      want = due_reports.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: expected %s / actual %s", $time, show(want), show(got));
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lrts_pkg::lrts_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lrts_pkg::lrts_out_t out_data;

  int              idle_pct  = 0;
  int              stall_pct = 0;
  int              cycles    = 0;
  schedule_tracker tracker   = new();

  longest_remaining_time_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("longest_remaining_time_scheduler_unit: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_report(out_data);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input lrts_pkg::lrts_in_t item);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_item(item);
    @(negedge clk);
  endtask

  task automatic send_load(input int slot, input int id, input int burst);
    lrts_pkg::lrts_in_t item;
    item.kind    = lrts_pkg::KIND_LOAD;
    item.slot    = lrts_pkg::SLOT_FIELD_W'(slot);
    item.task_id = lrts_pkg::ID_W'(id);
    item.burst   = lrts_pkg::BURST_W'(burst);
    send_item(item);
  endtask

  task automatic send_tick();
    lrts_pkg::lrts_in_t item;
    item.kind    = lrts_pkg::KIND_TICK;
    item.slot    = lrts_pkg::SLOT_FIELD_W'($urandom_range(7));
    item.task_id = lrts_pkg::ID_W'($urandom);
    item.burst   = lrts_pkg::BURST_W'($urandom);
    send_item(item);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.due_reports.size() != 0) @(negedge clk);
  endtask

  function automatic lrts_pkg::lrts_in_t random_item();
    lrts_pkg::lrts_in_t item;
    int                 pick;
    item.kind    = ($urandom_range(99) < 55) ? lrts_pkg::KIND_TICK : lrts_pkg::KIND_LOAD;
    item.slot    = lrts_pkg::SLOT_FIELD_W'($urandom_range(7));
    item.task_id = ($urandom_range(3) == 0) ? lrts_pkg::ID_W'($urandom_range(3))
                                            : lrts_pkg::ID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)      item.burst = '0;
    else if (pick < 65) item.burst = lrts_pkg::BURST_W'($urandom_range(1, 6));
    else if (pick < 92) item.burst = lrts_pkg::BURST_W'($urandom_range(7, 40));
    else                item.burst = lrts_pkg::BURST_W'($urandom);
    return item;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, extreme load cancelled by a zero burst
    send_tick();
    send_load(0, 16'hFFFF, 16'hFFFF);
    send_load(0, 0, 0);
    send_tick();
    // equal remaining: lower id wins, then lower slot
    send_load(7, 16'h1234, 2);
    send_load(3, 16'h1230, 2);
    send_load(5, 16'h1230, 2);
    repeat (6) send_tick();
    send_tick();
    // overwrite of a pending slot
    send_load(1, 16'hFFFF, 1);
    send_load(2, 0, 3);
    send_tick();
    send_load(2, 16'h8000, 1);
    repeat (3) send_tick();
    // long task, preempted by cancelling
    send_load(6, 16'h5555, 16'hFFFF);
    send_load(4, 16'hAAAA, 16'h8000);
    send_tick();
    send_load(6, 16'h5555, 0);
    send_load(4, 16'hAAAA, 0);
    send_tick();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_item(random_item());
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end

    stall_pct = 0;
    repeat (SETTLE) @(negedge clk);
    if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
      $display("longest_remaining_time_scheduler_unit: match");
    end else begin
      $display("longest_remaining_time_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
